@@ design/cpd_pkg.sv @@
// ----------------------------------------------------------------------------
// cpd_pkg
// shared widths, codes and types of the close approach detector
// ----------------------------------------------------------------------------
`default_nettype none

package cpd_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int IDX_IN_W       = 16;
    localparam int TIME_W         = 40;
    localparam int POS_W          = 32;
    localparam int DIST_W         = 34;
    localparam int ADIST_W        = 34;
    localparam int ATIME_W        = 42;
    localparam int THR_W          = 32;

    localparam int IN_DATA_W      = 248;
    localparam int OUT_FIELDS_W   = IDX_IN_W + ADIST_W + ATIME_W;
    localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;

    // job differences
    localparam int H_W            = TIME_W + 2;
    localparam int E_W            = DIST_W + 1;

    // serial arithmetic unit
    localparam int MAG_W          = 128;
    localparam int SGN_W          = MAG_W + 1;
    localparam int WIDE_W         = 256;
    localparam int WCNT_W         = $clog2(WIDE_W);

    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = 1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd10000;
    localparam int DCLAMP_W = 41;
    localparam int TCLAMP_W = 45;
    localparam logic [DCLAMP_W-1:0] DIST_CLAMP = 41'h100_0000_0000;
    localparam logic [TCLAMP_W-1:0] TIME_CLAMP = 45'h1000_0000_0000;

    typedef enum logic [1:0] {
        TREND_NONE = 2'd0,
        TREND_FALL = 2'd1,
        TREND_RISE = 2'd2
    } trend_t;

    typedef enum logic [0:0] {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic              start;
        arith_op_t         op;
        logic [WIDE_W-1:0] a;
        logic [WIDE_W-1:0] b;
    } arith_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WIDE_W-1:0] result;
    } arith_rsp_t;

    // one reversal: middle point and offsets of the outer points
    typedef struct packed {
        logic [TIME_W-1:0] t2;
        logic [DIST_W-1:0] d2;
        logic [H_W-1:0]    h1;
        logic [H_W-1:0]    h3;
        logic [E_W-1:0]    e1;
        logic [E_W-1:0]    e3;
    } job_t;

endpackage

`default_nettype wire

@@ design/cpd_front.sv @@
// ----------------------------------------------------------------------------
// cpd_front
// distance per sample (three squares, bit-pair square root), trend tracking
// and history; queues a job at each fall-to-rise reversal
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_front
    import cpd_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    in_first,
    input  logic [IDX_IN_W-1:0]     in_index,
    input  logic [TIME_W-1:0]       in_time,
    input  logic [POS_W-1:0]        in_ax,
    input  logic [POS_W-1:0]        in_ay,
    input  logic [POS_W-1:0]        in_az,
    input  logic [POS_W-1:0]        in_bx,
    input  logic [POS_W-1:0]        in_by,
    input  logic [POS_W-1:0]        in_bz,
    output logic                    push_valid,
    output job_t                    push_job,
    output logic [INDEX_BITS-1:0]   push_idx,
    input  logic                    push_full
);

    localparam int RAD_W  = 68;
    localparam int ROOT_W = 34;
    localparam int REM_W  = ROOT_W + 3;
    localparam int IT_W   = $clog2(ROOT_W);
    localparam int SQ_W   = 2 * (POS_W + 1);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_SQ   = 4'b0010,
        F_ROOT = 4'b0100,
        F_UPD  = 4'b1000
    } fstate_t;

    function automatic logic [POS_W:0] abs_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
        logic [POS_W:0] d;
        begin
            d = {a[POS_W-1], a} - {b[POS_W-1], b};
            abs_diff = d[POS_W] ? (~d + 1'b1) : d;
        end
    endfunction

    fstate_t               state_reg, state_next;
    logic                  first_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [POS_W:0]        mag_reg [3];
    logic [1:0]            sq_cnt_reg;
    logic [RAD_W-1:0]      sum_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [IT_W-1:0]       it_reg;

    logic [DIST_W-1:0]     prev_reg;
    trend_t                trend_reg;
    logic [TIME_W-1:0]     ht_reg [2];
    logic [DIST_W-1:0]     hd_reg [2];
    logic [1:0]            seen_reg;

    logic [SQ_W-1:0]       sq;
    logic [RAD_W-1:0]      sum_next;
    logic [REM_W-1:0]      rem_sh;
    logic [REM_W-1:0]      trial;
    logic                  root_bit;

    logic [DIST_W-1:0]     dist_cur;
    logic [1:0]            seen_e;
    trend_t                trend_e;
    logic [DIST_W-1:0]     prev_e;
    logic                  rising;
    logic                  job_v;
    logic                  commit;

    assign in_ready = (state_reg == F_IDLE);

    assign sq       = mag_reg[sq_cnt_reg] * mag_reg[sq_cnt_reg];
    assign sum_next = sum_reg + RAD_W'(sq);

    // one root bit per cycle from the top bit pair of the radicand
    assign rem_sh   = {rem_reg[REM_W-3:0], sum_reg[RAD_W-1:RAD_W-2]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign root_bit = (rem_sh >= trial);

    assign dist_cur = root_reg[DIST_W-1:0];
    assign seen_e  = first_reg ? 2'd0 : seen_reg;
    assign trend_e = first_reg ? TREND_NONE : trend_reg;
    assign prev_e  = first_reg ? '0 : prev_reg;
    assign rising  = !(dist_cur < prev_e);
    assign job_v   = (seen_e == 2'd2) && rising && (trend_e == TREND_FALL);
    assign commit  = (state_reg == F_UPD) && !(job_v && push_full);

    assign push_valid  = (state_reg == F_UPD) && job_v;
    assign push_idx    = idx_reg;
    assign push_job.t2 = ht_reg[0];
    assign push_job.d2 = hd_reg[0];
    assign push_job.h1 = {2'b00, ht_reg[1]} - {2'b00, ht_reg[0]};
    assign push_job.h3 = {2'b00, time_reg} - {2'b00, ht_reg[0]};
    assign push_job.e1 = {1'b0, hd_reg[1]} - {1'b0, hd_reg[0]};
    assign push_job.e3 = {1'b0, dist_cur} - {1'b0, hd_reg[0]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_SQ;
                end
            end
            F_SQ:
            begin
                if (sq_cnt_reg == 2'd2)
                begin
                    state_next = F_ROOT;
                end
            end
            F_ROOT:
            begin
                if (it_reg == IT_W'(ROOT_W - 1))
                begin
                    state_next = F_UPD;
                end
            end
            F_UPD:
            begin
                if (commit)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            prev_reg   <= '0;
            trend_reg  <= TREND_NONE;
            ht_reg[0]  <= '0;
            ht_reg[1]  <= '0;
            hd_reg[0]  <= '0;
            hd_reg[1]  <= '0;
            seen_reg   <= 2'd0;
            sq_cnt_reg <= 2'd0;
            it_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_IDLE)
            begin
                sq_cnt_reg <= 2'd0;
            end
            else if (state_reg == F_SQ)
            begin
                sq_cnt_reg <= sq_cnt_reg + 2'd1;
                it_reg     <= '0;
            end
            else if (state_reg == F_ROOT)
            begin
                it_reg <= it_reg + 1'b1;
            end
            if (commit)
            begin
                trend_reg <= (seen_e != 2'd0) ? (rising ? TREND_RISE : TREND_FALL) : trend_e;
                prev_reg  <= dist_cur;
                ht_reg[1] <= first_reg ? '0 : ht_reg[0];
                ht_reg[0] <= time_reg;
                hd_reg[1] <= first_reg ? '0 : hd_reg[0];
                hd_reg[0] <= dist_cur;
                seen_reg  <= (seen_e == 2'd2) ? 2'd2 : seen_e + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == F_IDLE) && in_valid)
        begin
            first_reg  <= in_first;
            idx_reg    <= INDEX_BITS'(in_index);
            time_reg   <= in_time;
            mag_reg[0] <= abs_diff(in_ax, in_bx);
            mag_reg[1] <= abs_diff(in_ay, in_by);
            mag_reg[2] <= abs_diff(in_az, in_bz);
            sum_reg    <= '0;
        end
        else if (state_reg == F_SQ)
        begin
            sum_reg  <= sum_next;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (state_reg == F_ROOT)
        begin
            sum_reg  <= {sum_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= root_bit ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], root_bit};
        end
    end

endmodule

`default_nettype wire

@@ design/cpd_queue.sv @@
// ----------------------------------------------------------------------------
// cpd_queue
// two-entry job queue between the sample front and the vertex back
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_queue
    import cpd_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  job_t                  push_job,
    input  logic [INDEX_BITS-1:0] push_idx,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output job_t                  head_job,
    output logic [INDEX_BITS-1:0] head_idx
);

    job_t                  job_mem [QDEPTH];
    logic [INDEX_BITS-1:0] idx_mem [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W:0]       count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push_valid && !full;
    assign do_pop   = pop && !empty;
    assign head_job = job_mem[rd_ptr_reg];
    assign head_idx = idx_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            job_mem[wr_ptr_reg] <= push_job;
            idx_mem[wr_ptr_reg] <= push_idx;
        end
    end

endmodule

`default_nettype wire

@@ design/cpd_arith.sv @@
// ----------------------------------------------------------------------------
// cpd_arith
// serial wide unit: shift-add multiply (one multiplier bit a cycle, stops
// when the multiplier runs out) and restoring divide (one quotient bit a cycle)
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_arith
    import cpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  arith_req_t req,
    output arith_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    arith_op_t         op_reg;
    logic [WIDE_W-1:0] acc_reg;
    logic [WIDE_W-1:0] x_reg;
    logic [WIDE_W-1:0] y_reg;
    logic [WCNT_W-1:0] cnt_reg;
    logic [WIDE_W-1:0] rem_sh;
    logic              q_bit;

    assign rem_sh = {acc_reg[WIDE_W-2:0], x_reg[WIDE_W-1]};
    assign q_bit  = (rem_sh >= y_reg);

    assign rsp.busy   = busy_reg;
    assign rsp.done   = done_reg;
    assign rsp.result = (op_reg == OP_MUL) ? acc_reg : x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                op_reg   <= req.op;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                case (op_reg)
                    OP_MUL:
                    begin
                        if (y_reg == '0)
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    OP_DIV:
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        if (cnt_reg == '0)
                        begin
                            busy_reg <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                        busy_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            acc_reg <= '0;
            x_reg   <= req.a;
            y_reg   <= req.b;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_MUL)
            begin
                if (y_reg[0])
                begin
                    acc_reg <= acc_reg + x_reg;
                end
                x_reg <= {x_reg[WIDE_W-2:0], 1'b0};
                y_reg <= {1'b0, y_reg[WIDE_W-1:1]};
            end
            else
            begin
                // numerator shifts out the top while quotient bits enter below
                acc_reg <= q_bit ? (rem_sh - y_reg) : rem_sh;
                x_reg   <= {x_reg[WIDE_W-2:0], q_bit};
            end
        end
    end

endmodule

`default_nettype wire

@@ design/cpd_back.sv @@
// ----------------------------------------------------------------------------
// cpd_back
// vertex sequencer: builds P, Q, D through the serial unit, divides for the
// vertex distance and time, saturates, tests the threshold, holds the result
// ----------------------------------------------------------------------------
`default_nettype none

module cpd_back
    import cpd_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [THR_W-1:0]      cfg_wdata,
    output logic                  pop,
    input  logic                  empty,
    input  job_t                  head_job,
    input  logic [INDEX_BITS-1:0] head_idx,
    output arith_req_t            arith_req,
    input  arith_rsp_t            arith_rsp,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [IDX_IN_W-1:0]   out_index,
    output logic [ADIST_W-1:0]    out_dist,
    output logic [ATIME_W-1:0]    out_time
);

    localparam int DSUM_W = DCLAMP_W + 5;
    localparam int TSUM_W = TCLAMP_W + 2;

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_ISSUE = 4'b0010,
        B_WAIT  = 4'b0100,
        B_FINAL = 4'b1000
    } bstate_t;

    typedef enum logic [3:0] {
        ST_E1H3   = 4'd0,
        ST_E3H1   = 4'd1,
        ST_H1SQ   = 4'd2,
        ST_H1SQE3 = 4'd3,
        ST_H3SQ   = 4'd4,
        ST_H3SQE1 = 4'd5,
        ST_H1H3   = 4'd6,
        ST_DEN_D  = 4'd7,
        ST_QSQ    = 4'd8,
        ST_PD     = 4'd9,
        ST_DIV_D  = 4'd10,
        ST_DIV_T  = 4'd11
    } step_t;

    function automatic logic [SGN_W-1:0] to_sgn(logic [WIDE_W-1:0] r, logic neg);
        logic [SGN_W-1:0] t;
        begin
            t = r[SGN_W-1:0];
            to_sgn = neg ? (~t + 1'b1) : t;
        end
    endfunction

    bstate_t               state_reg;
    step_t                 step_reg;
    logic [THR_W-1:0]      thr_reg;
    logic [INDEX_BITS-1:0] idx_reg;
    logic [TIME_W-1:0]     t2_reg;
    logic [DIST_W-1:0]     d2_reg;
    logic [H_W-1:0]        mh1_reg, mh3_reg, mhd_reg;
    logic [E_W-1:0]        me1_reg, me3_reg;
    logic                  sh1_reg, sh3_reg, shd_reg, se1_reg, se3_reg;
    logic [SGN_W-1:0]      x_reg, p_reg, q_reg;
    logic [MAG_W-1:0]      m_reg, dmag_reg;
    logic                  dneg_reg;
    logic [WIDE_W-1:0]     n_reg, den_reg;
    logic [ADIST_W-1:0]    vd_reg;
    logic [ATIME_W-1:0]    vt_reg;
    logic                  out_valid_reg;
    logic [IDX_IN_W-1:0]   out_index_reg;
    logic [ADIST_W-1:0]    out_dist_reg;
    logic [ATIME_W-1:0]    out_time_reg;

    logic [H_W:0]          hd;
    logic [H_W-1:0]        h1n, h3n;
    logic [E_W-1:0]        e1n, e3n;
    logic [SGN_W-1:0]      p_neg, q_neg;
    logic [MAG_W-1:0]      abs_p, abs_q;
    logic [WIDE_W-1:0]     res;
    logic [DCLAMP_W-1:0]   qd;
    logic [TCLAMP_W-1:0]   qt;
    logic [DSUM_W-1:0]     ds;
    logic [TSUM_W-1:0]     ts;
    logic [ADIST_W-1:0]    vd_sat;
    logic [ATIME_W-1:0]    vt_sat;
    logic                  hit;
    logic                  out_free;

    assign pop = (state_reg == B_IDLE) && !empty;

    assign hd  = {head_job.h1[H_W-1], head_job.h1} - {head_job.h3[H_W-1], head_job.h3};
    assign h1n = ~head_job.h1 + 1'b1;
    assign h3n = ~head_job.h3 + 1'b1;
    assign e1n = ~head_job.e1 + 1'b1;
    assign e3n = ~head_job.e3 + 1'b1;

    assign p_neg = ~p_reg + 1'b1;
    assign q_neg = ~q_reg + 1'b1;
    assign abs_p = p_reg[SGN_W-1] ? p_neg[MAG_W-1:0] : p_reg[MAG_W-1:0];
    assign abs_q = q_reg[SGN_W-1] ? q_neg[MAG_W-1:0] : q_reg[MAG_W-1:0];

    assign res = arith_rsp.result;

    // quotient magnitudes clamped, then added to or subtracted from the middle point and saturated
    assign qd = (res > WIDE_W'(DIST_CLAMP)) ? DIST_CLAMP : res[DCLAMP_W-1:0];
    assign qt = (res > WIDE_W'(TIME_CLAMP)) ? TIME_CLAMP : res[TCLAMP_W-1:0];
    assign ds = (p_reg[SGN_W-1] ^ dneg_reg) ? (DSUM_W'(d2_reg) + DSUM_W'(qd))
                                            : (DSUM_W'(d2_reg) - DSUM_W'(qd));
    assign ts = (q_reg[SGN_W-1] ^ p_reg[SGN_W-1]) ? (TSUM_W'(t2_reg) + TSUM_W'(qt))
                                                  : (TSUM_W'(t2_reg) - TSUM_W'(qt));

    always_comb
    begin
        if ((ds[DSUM_W-1:ADIST_W-1] == '0) || (ds[DSUM_W-1:ADIST_W-1] == '1))
        begin
            vd_sat = ds[ADIST_W-1:0];
        end
        else
        begin
            vd_sat = {ds[DSUM_W-1], {(ADIST_W-1){~ds[DSUM_W-1]}}};
        end
        if ((ts[TSUM_W-1:ATIME_W-1] == '0) || (ts[TSUM_W-1:ATIME_W-1] == '1))
        begin
            vt_sat = ts[ATIME_W-1:0];
        end
        else
        begin
            vt_sat = {ts[TSUM_W-1], {(ATIME_W-1){~ts[TSUM_W-1]}}};
        end
    end

    assign hit      = $signed({vd_reg[ADIST_W-1], vd_reg}) < $signed({3'b000, thr_reg});
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        arith_req.start = (state_reg == B_ISSUE);
        arith_req.op    = OP_MUL;
        arith_req.a     = '0;
        arith_req.b     = '0;
        case (step_reg)
            ST_E1H3:
            begin
                arith_req.a = WIDE_W'(me1_reg);
                arith_req.b = WIDE_W'(mh3_reg);
            end
            ST_E3H1:
            begin
                arith_req.a = WIDE_W'(me3_reg);
                arith_req.b = WIDE_W'(mh1_reg);
            end
            ST_H1SQ:
            begin
                arith_req.a = WIDE_W'(mh1_reg);
                arith_req.b = WIDE_W'(mh1_reg);
            end
            ST_H1SQE3:
            begin
                arith_req.a = WIDE_W'(m_reg);
                arith_req.b = WIDE_W'(me3_reg);
            end
            ST_H3SQ:
            begin
                arith_req.a = WIDE_W'(mh3_reg);
                arith_req.b = WIDE_W'(mh3_reg);
            end
            ST_H3SQE1:
            begin
                arith_req.a = WIDE_W'(m_reg);
                arith_req.b = WIDE_W'(me1_reg);
            end
            ST_H1H3:
            begin
                arith_req.a = WIDE_W'(mh1_reg);
                arith_req.b = WIDE_W'(mh3_reg);
            end
            ST_DEN_D:
            begin
                arith_req.a = WIDE_W'(m_reg);
                arith_req.b = WIDE_W'(mhd_reg);
            end
            ST_QSQ:
            begin
                arith_req.a = WIDE_W'(abs_q);
                arith_req.b = WIDE_W'(abs_q);
            end
            ST_PD:
            begin
                arith_req.a = WIDE_W'(abs_p);
                arith_req.b = WIDE_W'(dmag_reg);
            end
            ST_DIV_D:
            begin
                arith_req.op = OP_DIV;
                arith_req.a  = n_reg;
                arith_req.b  = den_reg;
            end
            ST_DIV_T:
            begin
                arith_req.op = OP_DIV;
                arith_req.a  = WIDE_W'(abs_q);
                arith_req.b  = WIDE_W'({abs_p, 1'b0});
            end
            default:
            begin
                arith_req.op = OP_MUL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= ST_E1H3;
            thr_reg       <= THRESHOLD_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            // a new result loaded in the same cycle keeps the valid flag set
            if (out_valid_reg && out_ready && !((state_reg == B_FINAL) && hit))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        step_reg  <= ST_E1H3;
                        state_reg <= B_ISSUE;
                    end
                end
                B_ISSUE:
                begin
                    state_reg <= B_WAIT;
                end
                B_WAIT:
                begin
                    if (arith_rsp.done)
                    begin
                        step_reg <= step_t'(step_reg + 4'd1);
                        if (step_reg == ST_DIV_T)
                        begin
                            state_reg <= B_FINAL;
                        end
                        else if ((step_reg == ST_DEN_D) &&
                                 ((p_reg == '0) || (res[MAG_W-1:0] == '0)))
                        begin
                            // flat or degenerate fit
                            state_reg <= B_FINAL;
                        end
                        else
                        begin
                            state_reg <= B_ISSUE;
                        end
                    end
                end
                B_FINAL:
                begin
                    if (!hit)
                    begin
                        state_reg <= B_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            idx_reg <= head_idx;
            t2_reg  <= head_job.t2;
            d2_reg  <= head_job.d2;
            sh1_reg <= head_job.h1[H_W-1];
            sh3_reg <= head_job.h3[H_W-1];
            se1_reg <= head_job.e1[E_W-1];
            se3_reg <= head_job.e3[E_W-1];
            shd_reg <= hd[H_W];
            mh1_reg <= head_job.h1[H_W-1] ? h1n : head_job.h1;
            mh3_reg <= head_job.h3[H_W-1] ? h3n : head_job.h3;
            me1_reg <= head_job.e1[E_W-1] ? e1n : head_job.e1;
            me3_reg <= head_job.e3[E_W-1] ? e3n : head_job.e3;
            mhd_reg <= hd[H_W] ? H_W'(~hd + 1'b1) : hd[H_W-1:0];
        end
        if ((state_reg == B_WAIT) && arith_rsp.done)
        begin
            case (step_reg)
                ST_E1H3:   x_reg <= to_sgn(res, se1_reg ^ sh3_reg);
                ST_E3H1:   p_reg <= x_reg - to_sgn(res, se3_reg ^ sh1_reg);
                ST_H1SQ:   m_reg <= res[MAG_W-1:0];
                ST_H1SQE3: x_reg <= to_sgn(res, se3_reg);
                ST_H3SQ:   m_reg <= res[MAG_W-1:0];
                ST_H3SQE1: q_reg <= x_reg - to_sgn(res, se1_reg);
                ST_H1H3:   m_reg <= res[MAG_W-1:0];
                ST_DEN_D:
                begin
                    dmag_reg <= res[MAG_W-1:0];
                    dneg_reg <= sh1_reg ^ sh3_reg ^ shd_reg;
                    vd_reg   <= '0;
                    vt_reg   <= '0;
                end
                ST_QSQ:    n_reg   <= res;
                ST_PD:     den_reg <= {res[WIDE_W-3:0], 2'b00};
                ST_DIV_D:  vd_reg  <= vd_sat;
                ST_DIV_T:  vt_reg  <= vt_sat;
                default:   m_reg   <= m_reg;
            endcase
        end
        if ((state_reg == B_FINAL) && hit && out_free)
        begin
            out_index_reg <= IDX_IN_W'(idx_reg);
            out_dist_reg  <= vd_reg;
            out_time_reg  <= vt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_dist  = out_dist_reg;
    assign out_time  = out_time_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        arith_req.start |-> !arith_rsp.busy)
        else $error("serial unit started while busy");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        arith_rsp.done |-> (state_reg == B_WAIT))
        else $error("serial result arrived outside the wait state");

    a_issue_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_ISSUE) |=> ((state_reg == B_WAIT) && arith_rsp.busy))
        else $error("issued step did not start the serial unit");

endmodule

`default_nettype wire

@@ design/close_approach_parabolic_detector_unit.sv @@
// ----------------------------------------------------------------------------
// close_approach_parabolic_detector_unit
// per-sample distance and trend; parabolic vertex at each reversal, reported
// when the vertex distance is below the threshold
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  s_axis   in   s_axis_tvalid/tready   tdata: sample fields, tuser: first_sample
//  m_axis   out  m_axis_tvalid/tready   tdata: hit_index, distance, time
//  cfg      in   cfg_we                 cfg_wdata: approach_threshold
//
//  a sample passes through the front in 3 squares, 34 root steps and 1 update;
//  the bit-pair square root sets the number of root steps
//  a reversal in the back runs eight shift-add products for a flat or degenerate
//  fit, otherwise ten shift-add products (one multiplier bit a cycle) and two
//  restoring divisions of 256 bits
//  the two-entry queue holds pending reversals; the front stalls when it is
//  full and the back stalls while a result waits on m_axis
//  reset clears all control and history, threshold returns to 10000
// ----------------------------------------------------------------------------
`default_nettype none

module close_approach_parabolic_detector_unit
    import cpd_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // object_index, sample_time, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // first_sample
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // hit_index, approach_distance, approach_time, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [THR_W-1:0]      cfg_wdata
);

    localparam int OUT_PAD_W = OUT_DATA_W - OUT_FIELDS_W;

    logic                  push_valid;
    job_t                  push_job;
    logic [INDEX_BITS-1:0] push_idx;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    job_t                  head_job;
    logic [INDEX_BITS-1:0] head_idx;
    arith_req_t            arith_req;
    arith_rsp_t            arith_rsp;
    logic [IDX_IN_W-1:0]   out_index;
    logic [ADIST_W-1:0]    out_dist;
    logic [ATIME_W-1:0]    out_time;

    cpd_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_first   (s_axis_tuser),
        .in_index   (s_axis_tdata[15:0]),
        .in_time    (s_axis_tdata[55:16]),
        .in_ax      (s_axis_tdata[87:56]),
        .in_ay      (s_axis_tdata[119:88]),
        .in_az      (s_axis_tdata[151:120]),
        .in_bx      (s_axis_tdata[183:152]),
        .in_by      (s_axis_tdata[215:184]),
        .in_bz      (s_axis_tdata[247:216]),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_idx   (push_idx),
        .push_full  (q_full)
    );

    cpd_queue #(
        .INDEX_BITS (INDEX_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_idx   (push_idx),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head_job   (head_job),
        .head_idx   (head_idx)
    );

    cpd_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (arith_req),
        .rsp   (arith_rsp)
    );

    cpd_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_job  (head_job),
        .head_idx  (head_idx),
        .arith_req (arith_req),
        .arith_rsp (arith_rsp),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_index (out_index),
        .out_dist  (out_dist),
        .out_time  (out_time)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_time, out_dist, out_index};

endmodule

`default_nettype wire
